### rtl/log_log_absorption_lookup_unit_defines.svh
// Shared assertion macros for the lookup unit
`ifndef LOG_LOG_ABSORPTION_LOOKUP_UNIT_DEFINES_SVH
`define LOG_LOG_ABSORPTION_LOOKUP_UNIT_DEFINES_SVH

// same-cycle implication
`define LLAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LLAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/llal_pkg.sv
`default_nettype none
package llal_pkg;

    localparam int EN_W     = 32;
    localparam int MU_W     = 40;
    localparam int LOG_W    = 30;
    localparam int LFRAC    = 24;
    localparam int LOG_OPS  = 5;
    localparam logic [MU_W-1:0] MU_MAX = {MU_W{1'b1}};

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_ELEM = 2'd1;
    localparam logic [1:0] STATUS_BELOW    = 2'd2;
    localparam logic [1:0] STATUS_ABOVE    = 2'd3;

    typedef struct packed {
        logic            func;
        logic [7:0]      element;
        logic [5:0]      slot;
        logic [EN_W-1:0] energy;
        logic [MU_W-1:0] coef;
        logic            last_pair;
    } req_item_t;

    typedef struct packed {
        logic [MU_W-1:0] mu;
        logic [1:0]      status;
    } rsp_item_t;

    typedef logic [LOG_W-1:0] log_t;

    typedef enum logic {
        OP_LOG2   = 1'b0,
        OP_INTERP = 1'b1
    } math_op_t;

    typedef struct packed {
        logic     start;
        math_op_t op;
    } math_req_t;

    typedef struct packed {
        logic            done;
        logic [MU_W-1:0] result;
    } math_rsp_t;

    typedef struct packed {
        log_t lmb;
        log_t lms;
        log_t lkb;
        log_t lks;
        log_t lk;
    } interp_ops_t;

    typedef logic [LFRAC-1:0][31:0] root_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] value);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = value;
        r = 64'd0;
        for (int j = 31; j >= 0; j--) begin
            b = 64'd1 << (2 * j);
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // entry k holds 2^(2^-(LFRAC-k)) in Q1.31
    function automatic root_tab_t exp2_roots();
        root_tab_t   tab;
        logic [63:0] c;
        c = 64'h1_0000_0000;
        for (int k = LFRAC - 1; k >= 0; k--) begin
            c = isqrt64(c << 31);
            tab[k] = c[31:0];
        end
        return tab;
    endfunction

    localparam root_tab_t EXP2_ROOTS = exp2_roots();

endpackage
`default_nettype wire

### rtl/log_log_absorption_lookup_unit.sv
// Log-log absorption lookup unit.
// Request channel (req_valid/req_ready/req): func 0 loads one energy and
// coefficient pair into an element's table; func 1 queries a coefficient.
// Response channel (rsp_valid/rsp_ready/rsp): one item per query, none per load.
// A load is accepted and the unit stays ready. A query holds req_ready low
// until its result is registered. A bad element goes straight to the result;
// otherwise the unit reads the pair count and searches the table serially
// (one energy RAM read per entry). With no entries the result is zero; an
// energy at or below the first entry or above the last returns that entry's
// coefficient, and one in between is interpolated from two coefficients: five
// log2 runs and the exp2 run share one 32x32 multiplier, and a bit-serial
// 62-bit divider runs between them.
// Reset clears every pair count; table RAMs need no clearing and are valid
// once written. A result waits in the output register while the receiver
// stalls; the next item is still taken, and a later query result waits in
// the unit until that register is free.
`default_nettype none
module log_log_absorption_lookup_unit #(
    parameter int MAX_ELEMENTS = 128,
    parameter int MAX_PAIRS    = 64
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire llal_pkg::req_item_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output llal_pkg::rsp_item_t      rsp
);
    import llal_pkg::*;

    localparam int DEPTH = MAX_ELEMENTS * MAX_PAIRS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int EW    = MAX_ELEMENTS > 1 ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW    = $clog2(MAX_PAIRS + 1);

    typedef enum logic [13:0] {
        ST_IDLE   = 14'h0001,
        ST_PC_RD  = 14'h0002,
        ST_PC_WT  = 14'h0004,
        ST_S_RD   = 14'h0008,
        ST_S_CMP  = 14'h0010,
        ST_HI_RD  = 14'h0020,
        ST_HI_WT  = 14'h0040,
        ST_LO_RD  = 14'h0080,
        ST_LO_WT  = 14'h0100,
        ST_LG_GO  = 14'h0200,
        ST_LG_WT  = 14'h0400,
        ST_IP_GO  = 14'h0800,
        ST_IP_WT  = 14'h1000,
        ST_RESULT = 14'h2000
    } state_t;

    state_t            state_reg, state_next;
    logic [MAX_ELEMENTS-1:0] pc_valid_reg, pc_valid_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_item_t         rsp_reg, rsp_next;
    logic [EW-1:0]     eidx_reg, eidx_next;
    logic [EN_W-1:0]   kev_reg, kev_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic              final_reg, final_next;
    logic [1:0]        status_reg, status_next;
    logic [MU_W-1:0]   mu_reg, mu_next;
    logic [EN_W-1:0]   e_hi_reg, e_hi_next;
    logic [EN_W-1:0]   e_lo_reg, e_lo_next;
    logic [MU_W-1:0]   c_hi_reg, c_hi_next;
    logic [MU_W-1:0]   c_lo_reg, c_lo_next;
    logic [2:0]        lg_idx_reg, lg_idx_next;
    log_t              lg_reg [LOG_OPS];

    logic              accept;
    logic              el_ok;
    logic              slot_ok;
    logic [EW-1:0]     in_eidx;
    logic [AW-1:0]     in_addr;
    logic [AW-1:0]     base;
    logic              tab_we;
    logic              pc_we;
    logic              pc_re;
    logic [CW-1:0]     pc_rdata;
    logic              e_re;
    logic [AW-1:0]     e_raddr;
    logic [EN_W-1:0]   e_rdata;
    logic              c_re;
    logic [AW-1:0]     c_raddr;
    logic [MU_W-1:0]   c_rdata;
    math_req_t         m_req;
    math_rsp_t         m_rsp;
    logic [MU_W-1:0]   m_x;
    interp_ops_t       m_ops;

    assign accept  = req_valid && req_ready;
    assign el_ok   = (req.element != 8'd0) && ({1'b0, req.element} <= 9'(MAX_ELEMENTS));
    assign slot_ok = int'(req.slot) < MAX_PAIRS;
    assign in_eidx = EW'(req.element - 8'd1);
    assign in_addr = AW'(in_eidx) * AW'(MAX_PAIRS) + AW'(req.slot);
    assign base    = AW'(eidx_reg) * AW'(MAX_PAIRS);
    assign tab_we  = accept && (req.func == FUNC_LOAD) && el_ok && slot_ok;
    assign pc_we   = tab_we && req.last_pair;
    assign pc_re   = (state_reg == ST_PC_RD);
    assign e_re    = (state_reg == ST_S_RD);
    assign e_raddr = base + AW'(i_reg);
    assign c_re    = (state_reg == ST_HI_RD) || (state_reg == ST_LO_RD);
    assign c_raddr = (state_reg == ST_LO_RD) ? (base + AW'(hi_reg) - AW'(1))
                                             : (base + AW'(hi_reg));

    llal_ram #(.WIDTH(EN_W), .DEPTH(DEPTH)) u_energy_ram (
        .clk     (clk),
        .wr_en   (tab_we),
        .wr_addr (in_addr),
        .wr_data (req.energy),
        .rd_en   (e_re),
        .rd_addr (e_raddr),
        .rd_data (e_rdata)
    );

    llal_ram #(.WIDTH(MU_W), .DEPTH(DEPTH)) u_coef_ram (
        .clk     (clk),
        .wr_en   (tab_we),
        .wr_addr (in_addr),
        .wr_data (req.coef),
        .rd_en   (c_re),
        .rd_addr (c_raddr),
        .rd_data (c_rdata)
    );

    llal_ram #(.WIDTH(CW), .DEPTH(MAX_ELEMENTS)) u_count_ram (
        .clk     (clk),
        .wr_en   (pc_we),
        .wr_addr (in_eidx),
        .wr_data (CW'(req.slot) + CW'(1)),
        .rd_en   (pc_re),
        .rd_addr (eidx_reg),
        .rd_data (pc_rdata)
    );

    always_comb
    begin
        unique case (lg_idx_reg)
            3'd0:    m_x = c_hi_reg;
            3'd1:    m_x = c_lo_reg;
            3'd2:    m_x = MU_W'(e_hi_reg);
            3'd3:    m_x = MU_W'(e_lo_reg);
            default: m_x = MU_W'(kev_reg);
        endcase
    end

    assign m_ops.lmb = lg_reg[0];
    assign m_ops.lms = lg_reg[1];
    assign m_ops.lkb = lg_reg[2];
    assign m_ops.lks = lg_reg[3];
    assign m_ops.lk  = lg_reg[4];
    assign m_req.start = (state_reg == ST_LG_GO) || (state_reg == ST_IP_GO);
    assign m_req.op    = (state_reg == ST_IP_GO) ? OP_INTERP : OP_LOG2;

    llal_math u_math (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (m_req),
        .x     (m_x),
        .ops   (m_ops),
        .rsp   (m_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        pc_valid_next  = pc_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        eidx_next      = eidx_reg;
        kev_next       = kev_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        hi_next        = hi_reg;
        final_next     = final_reg;
        status_next    = status_reg;
        mu_next        = mu_reg;
        e_hi_next      = e_hi_reg;
        e_lo_next      = e_lo_reg;
        c_hi_next      = c_hi_reg;
        c_lo_next      = c_lo_reg;
        lg_idx_next    = lg_idx_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (pc_we)
        begin
            pc_valid_next[in_eidx] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.func == FUNC_QUERY))
                begin
                    eidx_next = in_eidx;
                    kev_next  = req.energy;
                    if (el_ok)
                    begin
                        state_next = ST_PC_RD;
                    end else begin
                        mu_next     = '0;
                        status_next = STATUS_BAD_ELEM;
                        state_next  = ST_RESULT;
                    end
                end
            end
            ST_PC_RD:
            begin
                state_next = ST_PC_WT;
            end
            ST_PC_WT:
            begin
                n_next     = pc_valid_reg[eidx_reg] ? pc_rdata : '0;
                i_next     = '0;
                state_next = ST_S_RD;
            end
            ST_S_RD:
            begin
                if (i_reg == n_reg)
                begin
                    status_next = STATUS_ABOVE;
                    if (n_reg == '0)
                    begin
                        mu_next    = '0;
                        state_next = ST_RESULT;
                    end else begin
                        hi_next    = n_reg - CW'(1);
                        final_next = 1'b1;
                        state_next = ST_HI_RD;
                    end
                end else begin
                    state_next = ST_S_CMP;
                end
            end
            ST_S_CMP:
            begin
                if (e_rdata < kev_reg)
                begin
                    e_lo_next  = e_rdata;
                    i_next     = i_reg + CW'(1);
                    state_next = ST_S_RD;
                end else begin
                    e_hi_next  = e_rdata;
                    hi_next    = i_reg;
                    if (i_reg == '0)
                    begin
                        status_next = STATUS_BELOW;
                        final_next  = 1'b1;
                    end else begin
                        status_next = STATUS_OK;
                        final_next  = 1'b0;
                    end
                    state_next = ST_HI_RD;
                end
            end
            ST_HI_RD:
            begin
                state_next = ST_HI_WT;
            end
            ST_HI_WT:
            begin
                c_hi_next = c_rdata;
                if (final_reg)
                begin
                    mu_next    = c_rdata;
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_LO_RD;
                end
            end
            ST_LO_RD:
            begin
                state_next = ST_LO_WT;
            end
            ST_LO_WT:
            begin
                c_lo_next   = c_rdata;
                lg_idx_next = '0;
                state_next  = ST_LG_GO;
            end
            ST_LG_GO:
            begin
                state_next = ST_LG_WT;
            end
            ST_LG_WT:
            begin
                if (m_rsp.done)
                begin
                    if (lg_idx_reg == 3'(LOG_OPS - 1))
                    begin
                        state_next = ST_IP_GO;
                    end else begin
                        lg_idx_next = lg_idx_reg + 3'd1;
                        state_next  = ST_LG_GO;
                    end
                end
            end
            ST_IP_GO:
            begin
                state_next = ST_IP_WT;
            end
            ST_IP_WT:
            begin
                if (m_rsp.done)
                begin
                    mu_next    = m_rsp.result;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.mu     = mu_reg;
                    rsp_next.status = status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_valid_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pc_valid_reg  <= pc_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg    <= rsp_next;
        eidx_reg   <= eidx_next;
        kev_reg    <= kev_next;
        n_reg      <= n_next;
        i_reg      <= i_next;
        hi_reg     <= hi_next;
        final_reg  <= final_next;
        status_reg <= status_next;
        mu_reg     <= mu_next;
        e_hi_reg   <= e_hi_next;
        e_lo_reg   <= e_lo_next;
        c_hi_reg   <= c_hi_next;
        c_lo_reg   <= c_lo_next;
        lg_idx_reg <= lg_idx_next;
        if ((state_reg == ST_LG_WT) && m_rsp.done)
        begin
            lg_reg[lg_idx_reg] <= m_rsp.result[LOG_W-1:0];
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
endmodule
`default_nettype wire

### rtl/llal_ram.sv
`default_nettype none
module llal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

### rtl/llal_math.sv
`default_nettype none
module llal_math (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire llal_pkg::math_req_t     req,
    input  wire logic [llal_pkg::MU_W-1:0] x,
    input  wire llal_pkg::interp_ops_t   ops,
    output llal_pkg::math_rsp_t          rsp
);
    import llal_pkg::*;

    typedef enum logic [10:0] {
        M_IDLE    = 11'h001,
        M_NORM    = 11'h002,
        M_SQ_MUL  = 11'h004,
        M_SQ_CHK  = 11'h008,
        M_D_MUL   = 11'h010,
        M_DIV     = 11'h020,
        M_E_SET   = 11'h040,
        M_E_MUL   = 11'h080,
        M_E_CHK   = 11'h100,
        M_E_SHIFT = 11'h200,
        M_DONE    = 11'h400
    } mstate_t;

    mstate_t          state_reg, state_next;
    logic [MU_W-1:0]  norm_reg, norm_next;
    logic [5:0]       p_reg, p_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [31:0]      mant_reg, mant_next;
    logic [63:0]      prod_reg, prod_next;
    logic [LFRAC-1:0] frac_reg, frac_next;
    logic [MU_W-1:0]  result_reg, result_next;
    logic [30:0]      dm_reg, dm_next;
    logic [30:0]      dk_reg, dk_next;
    logic [30:0]      den_reg, den_next;
    logic             neg_reg, neg_next;
    log_t             lmb_reg, lmb_next;
    logic [61:0]      quo_reg, quo_next;
    logic [30:0]      rem_reg, rem_next;
    logic [5:0]       q_reg, q_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_out;
    logic [30:0] dm_s, dk_s, den_s;
    logic [31:0] trial;
    logic [63:0] delta_s, l_sum;
    logic [32:0] sq;
    logic [70:0] wide;

    // shared multiplier
    always_comb
    begin
        unique case (state_reg)
            M_SQ_MUL: begin mul_a = mant_reg; mul_b = mant_reg; end
            M_D_MUL:  begin mul_a = {1'b0, dm_reg}; mul_b = {1'b0, dk_reg}; end
            default:  begin mul_a = mant_reg; mul_b = EXP2_ROOTS[cnt_reg[4:0]]; end
        endcase
    end
    assign mul_out = 64'(mul_a) * 64'(mul_b);

    assign dm_s    = {1'b0, ops.lmb} - {1'b0, ops.lms};
    assign dk_s    = {1'b0, ops.lk}  - {1'b0, ops.lkb};
    assign den_s   = {1'b0, ops.lkb} - {1'b0, ops.lks};
    assign trial   = {rem_reg, quo_reg[61]};
    assign sq      = prod_reg[63:31];
    assign delta_s = neg_reg ? (64'd0 - {2'b00, quo_reg}) : {2'b00, quo_reg};
    assign l_sum   = {{(64-LOG_W){1'b0}}, lmb_reg} + delta_s;
    assign wide    = {39'd0, mant_reg} << q_reg;

    always_comb
    begin
        state_next  = state_reg;
        norm_next   = norm_reg;
        p_next      = p_reg;
        cnt_next    = cnt_reg;
        mant_next   = mant_reg;
        prod_next   = prod_reg;
        frac_next   = frac_reg;
        result_next = result_reg;
        dm_next     = dm_reg;
        dk_next     = dk_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        lmb_next    = lmb_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    if (req.op == OP_LOG2)
                    begin
                        norm_next  = (x == '0) ? MU_W'(1) : x;
                        p_next     = 6'(MU_W - 1);
                        state_next = M_NORM;
                    end else begin
                        lmb_next = ops.lmb;
                        dm_next  = dm_s[30] ? 31'(0 - dm_s) : dm_s;
                        dk_next  = dk_s[30] ? 31'(0 - dk_s) : dk_s;
                        den_next = den_s[30] ? 31'(0 - den_s) : den_s;
                        neg_next = dm_s[30] ^ dk_s[30];
                        quo_next = '0;
                        if (den_s == '0)
                        begin
                            neg_next   = 1'b0;
                            state_next = M_E_SET;
                        end else begin
                            state_next = M_D_MUL;
                        end
                    end
                end
            end
            M_NORM:
            begin
                if (norm_reg[MU_W-1])
                begin
                    mant_next  = norm_reg[MU_W-1 -: 32];
                    frac_next  = '0;
                    cnt_next   = 6'(LFRAC - 1);
                    state_next = M_SQ_MUL;
                end else begin
                    norm_next = norm_reg << 1;
                    p_next    = p_reg - 6'd1;
                end
            end
            M_SQ_MUL:
            begin
                prod_next  = mul_out;
                state_next = M_SQ_CHK;
            end
            M_SQ_CHK:
            begin
                if (sq[32])
                begin
                    frac_next[cnt_reg[4:0]] = 1'b1;
                    mant_next = sq[32:1];
                end else begin
                    mant_next = sq[31:0];
                end
                if (cnt_reg == '0)
                begin
                    result_next = MU_W'({p_reg, frac_next});
                    state_next  = M_DONE;
                end else begin
                    cnt_next   = cnt_reg - 6'd1;
                    state_next = M_SQ_MUL;
                end
            end
            M_D_MUL:
            begin
                quo_next   = mul_out[61:0];
                rem_next   = '0;
                cnt_next   = 6'd61;
                state_next = M_DIV;
            end
            M_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = 31'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[60:0], 1'b1};
                end else begin
                    rem_next = trial[30:0];
                    quo_next = {quo_reg[60:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    state_next = M_E_SET;
                end else begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            M_E_SET:
            begin
                if (l_sum[63])
                begin
                    q_next     = '0;
                    frac_next  = '0;
                    mant_next  = 32'h8000_0000;
                    cnt_next   = 6'(LFRAC - 1);
                    state_next = M_E_MUL;
                end else if (l_sum[63:LFRAC] >= 40'(MU_W)) begin
                    result_next = MU_MAX;
                    state_next  = M_DONE;
                end else begin
                    q_next     = l_sum[LFRAC+5:LFRAC];
                    frac_next  = l_sum[LFRAC-1:0];
                    mant_next  = 32'h8000_0000;
                    cnt_next   = 6'(LFRAC - 1);
                    state_next = M_E_MUL;
                end
            end
            M_E_MUL:
            begin
                prod_next  = mul_out;
                state_next = M_E_CHK;
            end
            M_E_CHK:
            begin
                if (frac_reg[cnt_reg[4:0]])
                begin
                    mant_next = prod_reg[62:31];
                end
                if (cnt_reg == '0)
                begin
                    state_next = M_E_SHIFT;
                end else begin
                    cnt_next   = cnt_reg - 6'd1;
                    state_next = M_E_MUL;
                end
            end
            M_E_SHIFT:
            begin
                result_next = wide[70:31];
                state_next  = M_DONE;
            end
            M_DONE:
            begin
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg   <= norm_next;
        p_reg      <= p_next;
        cnt_reg    <= cnt_next;
        mant_reg   <= mant_next;
        prod_reg   <= prod_next;
        frac_reg   <= frac_next;
        result_reg <= result_next;
        dm_reg     <= dm_next;
        dk_reg     <= dk_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        lmb_reg    <= lmb_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
    end

    assign rsp.done   = (state_reg == M_DONE);
    assign rsp.result = result_reg;
endmodule
`default_nettype wire

### rtl/llal_chk.sv
`default_nettype none
`include "log_log_absorption_lookup_unit_defines.svh"
module llal_chk (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire llal_pkg::req_item_t req,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire llal_pkg::rsp_item_t rsp
);
    import llal_pkg::*;

    `LLAL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response item dropped")
    `LLAL_ASSERT_NOW(a_bad_zero, rsp_valid && (rsp.status == STATUS_BAD_ELEM), rsp.mu == '0, "bad element with nonzero mu")
    `LLAL_ASSERT_NEXT(a_query_busy, req_valid && req_ready && (req.func == FUNC_QUERY), !req_ready, "ready after query item")
    `LLAL_ASSERT_NEXT(a_load_ready, req_valid && req_ready && (req.func == FUNC_LOAD), req_ready, "not ready after load item")
endmodule

bind log_log_absorption_lookup_unit llal_chk u_llal_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire

### tb/lookup_checker.sv
`timescale 1ns / 100ps
module lookup_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic                req_ready,
    input  wire llal_pkg::req_item_t req,
    input  wire logic                rsp_valid,
    input  wire logic                rsp_ready,
    input  wire llal_pkg::rsp_item_t rsp,
    output int                       errors,
    output int                       pending
);
    import llal_pkg::*;

    localparam int N_EL = 128;
    localparam int N_PR = 64;

    logic [EN_W-1:0] energy_mem [N_EL*N_PR];
    logic [MU_W-1:0] coef_mem [N_EL*N_PR];
    int              pairs [N_EL];
    rsp_item_t       expected_q [$];
    logic [31:0]     roots [LFRAC];

    assign pending = expected_q.size();

    function automatic logic [63:0] root_of(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint log_fixed(input logic [63:0] x);
        int          p;
        logic [63:0] m;
        logic [63:0] res;
        if (x == 0) x = 1;
        p = 63;
        while (x[p] == 1'b0) p--;
        m = (p > 31) ? (x >> (p - 31)) : (x << (31 - p));
        res = 64'(p) << LFRAC;
        for (int k = LFRAC - 1; k >= 0; k--)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                res[k] = 1'b1;
                m = m >> 1;
            end
        end
        return longint'(res);
    endfunction

    function automatic logic [MU_W-1:0] exp_fixed(input longint l);
        logic [63:0] u;
        logic [63:0] q;
        logic [63:0] m;
        if (l < 0) l = 0;
        u = l;
        q = u >> LFRAC;
        m = 64'd1 << 31;
        if (q >= 40) return MU_MAX;
        for (int k = LFRAC - 1; k >= 0; k--)
            if (u[k]) m = (m * 64'(roots[k])) >> 31;
        m = (q >= 31) ? (m << (q - 31)) : (m >> (31 - q));
        return (m > 64'(MU_MAX)) ? MU_MAX : m[MU_W-1:0];
    endfunction

    function automatic rsp_item_t predict_coef(input req_item_t r);
        rsp_item_t o;
        int        base;
        int        n;
        int        i;
        longint    lmb;
        longint    lms;
        longint    lkb;
        longint    lks;
        longint    lk;
        longint    den;
        longint    delta;
        if (r.element < 1 || r.element > N_EL)
        begin
            o.mu = 0;
            o.status = STATUS_BAD_ELEM;
            return o;
        end
        base = (r.element - 1) * N_PR;
        n = pairs[r.element - 1];
        i = 0;
        while (i < n && energy_mem[base + i] < r.energy) i++;
        if (i == n)
        begin
            o.mu = n ? coef_mem[base + n - 1] : '0;
            o.status = STATUS_ABOVE;
        end
        else if (i == 0)
        begin
            o.mu = coef_mem[base];
            o.status = STATUS_BELOW;
        end
        else
        begin
            lmb = log_fixed(coef_mem[base + i]);
            lms = log_fixed(coef_mem[base + i - 1]);
            lkb = log_fixed(energy_mem[base + i]);
            lks = log_fixed(energy_mem[base + i - 1]);
            lk = log_fixed(r.energy);
            den = lkb - lks;
            delta = 0;
            if (den != 0) delta = ((lmb - lms) * (lk - lkb)) / den;
            o.mu = exp_fixed(lmb + delta);
            o.status = STATUS_OK;
        end
        return o;
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    initial
    begin
        logic [63:0] c;
        errors = 0;
        c = 64'h1_0000_0000;
        for (int k = LFRAC - 1; k >= 0; k--)
        begin
            c = root_of(c << 31);
            roots[k] = c[31:0];
        end
        for (int e = 0; e < N_EL; e++) pairs[e] = 0;
    end

    always @(posedge clk)
    begin
        rsp_item_t exp_item;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                if (req.func == FUNC_LOAD)
                begin
                    if (req.element >= 1 && req.element <= N_EL)
                    begin
                        energy_mem[(req.element - 1) * N_PR + req.slot] = req.energy;
                        coef_mem[(req.element - 1) * N_PR + req.slot] = req.coef;
                        if (req.last_pair) pairs[req.element - 1] = req.slot + 1;
                    end
                end
                else
                    expected_q.push_back(predict_coef(req));
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    exp_item = expected_q.pop_front();
                    if (rsp.mu !== exp_item.mu)
                        report($sformatf("mu %h, expected %h", rsp.mu, exp_item.mu));
                    if (rsp.status !== exp_item.status)
                        report($sformatf("status %0d, expected %0d", rsp.status,
                            exp_item.status));
                end
            end
        end
    end
endmodule

### tb/tb.sv
`timescale 1ns / 100ps
module tb;
    import llal_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_item_t rsp;
    int        errors;
    int        pending;
    int        send_idle;
    int        take_idle;
    bit        hold_off;
    int        filled [1:128];

    log_log_absorption_lookup_unit dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    lookup_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("FAIL log_log_absorption_lookup_unit");
        $finish;
    end

    always @(negedge clk)
        rsp_ready <= !hold_off && ($urandom_range(99) >= take_idle);

    // valid stays high past the accepting edge only until the next item or idle cycle
    task automatic send(input req_item_t item);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 0;
            @(negedge clk);
        end
        req <= item;
        req_valid <= 1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
        if (item.func == FUNC_LOAD && item.element >= 1 && item.element <= 128
            && item.last_pair && filled[item.element] < item.slot + 1)
            filled[item.element] = item.slot + 1;
    endtask

    function automatic req_item_t make_load(input int el, input int s,
        input logic [31:0] en, input logic [39:0] cf, input bit last);
        req_item_t r;
        r.func = FUNC_LOAD;
        r.element = 8'(el);
        r.slot = 6'(s);
        r.energy = en;
        r.coef = cf;
        r.last_pair = last;
        return r;
    endfunction

    function automatic req_item_t make_query(input int el, input logic [31:0] en);
        req_item_t r;
        r = req_item_t'(88'({$urandom, $urandom, $urandom}));
        r.func = FUNC_QUERY;
        r.element = 8'(el);
        r.energy = en;
        return r;
    endfunction

    function automatic logic [39:0] rand_coef();
        logic [39:0] c;
        c = 40'({$urandom, $urandom});
        return c >> $urandom_range(39);
    endfunction

    // fill every slot so queries never read unwritten entries
    task automatic load_table(input int el, input int n, input bit extreme);
        logic [31:0] en;
        logic [31:0] step;
        en = extreme ? 32'd0 : $urandom_range(1 << 20);
        for (int s = 0; s < n; s++)
        begin
            send(make_load(el, s, en, extreme && s == 0 ? 40'd0 :
                (extreme && s == n - 1 ? MU_MAX : rand_coef()), s == n - 1));
            step = $urandom_range(3) == 0 ? 0 : ($urandom >> $urandom_range(8, 31));
            en = (en > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : en + step;
            if (extreme && s == n - 2) en = 32'hFFFF_FFFF;
        end
    endtask

    task automatic random_item();
        int          el;
        int          r;
        logic [31:0] en;
        r = $urandom_range(99);
        el = $urandom_range(1, 12);
        if (r < 8)
            load_table(el, $urandom_range(1, 6), 0);
        else if (r < 13)
            send(make_query($urandom_range(1) ? 0 : $urandom_range(129, 255), $urandom));
        else if (r < 16)
            send(make_load($urandom_range(1) ? 0 : $urandom_range(129, 255),
                $urandom_range(63), $urandom, rand_coef(), $urandom_range(1)));
        else if (r < 20)
            send(make_query(filled[el] ? el : $urandom_range(100, 128), $urandom));
        else
        begin
            en = $urandom >> $urandom_range(31);
            if (filled[el] == 0) send(make_query($urandom_range(100, 128), en));
            else send(make_query(el, en));
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 0;
        req_valid = 0;
        req = '0;
        hold_off = 0;
        send_idle = 0;
        take_idle = 0;
        for (int e = 1; e <= 128; e++) filled[e] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send(make_query(128, 32'h1234));
        send(make_query(0, 0));
        send(make_query(255, 32'hFFFF_FFFF));
        load_table(1, 64, 1);
        load_table(128, 2, 1);
        load_table(2, 3, 0);
        send(make_query(1, 0));
        send(make_query(1, 32'hFFFF_FFFF));
        send(make_query(1, 32'h0001_0000));
        send(make_query(128, 32'h8000_0000));
        send(make_query(128, 32'hFFFF_FFFF));
        send(make_query(2, 32'hFFFF_FFFF));
        send(make_load(2, 0, 32'h0001_0000, 40'h10000, 0));
        send(make_load(2, 1, 32'h0001_0000, 40'h90000, 1));
        send(make_query(2, 32'h0001_0000));
        send(make_query(2, 32'h0000_8000));

        send_idle = 32;
        take_idle = 58;
        repeat (220) random_item();
        send_idle = 58;
        take_idle = 32;
        repeat (220) random_item();
        send_idle = 0;
        take_idle = 0;
        fork
            begin
                hold_off = 1;
                repeat (3000) @(negedge clk);
                hold_off = 0;
            end
            repeat (20) send(make_query(1, $urandom));
        join
        repeat (180) random_item();
        req_valid <= 0;

        waited = 0;
        while (pending != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (700) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS log_log_absorption_lookup_unit");
        else
            $display("FAIL log_log_absorption_lookup_unit");
        $finish;
    end
endmodule
